// File: src/bgl_pkg.sv
// bgl_pkg: shared constants and types for the binary gcd / lcm block
// no dependencies
`default_nettype none

package bgl_pkg;

    localparam int DATA_W        = 64;
    localparam int OPERAND_WIDTH = 64;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    localparam logic CMD_GCD = 1'b0;
    localparam logic CMD_LCM = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STRIP,
        ST_ODDX,
        ST_SUB,
        ST_SCALE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_status_t;

endpackage

`default_nettype wire

// File: src/bgl_core.sv
// bgl_core: sequencer and shared adder for stein gcd, restoring divide and shift-add multiply
// depends on bgl_pkg
`default_nettype none

module bgl_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic                                cmd,
    input  wire logic [bgl_pkg::OPERAND_WIDTH-1:0]   op_a,
    input  wire logic [bgl_pkg::OPERAND_WIDTH-1:0]   op_b,
    input  wire logic                                ack,
    output bgl_pkg::core_status_t                    status,
    output logic      [bgl_pkg::OPERAND_WIDTH-1:0]   res_value,
    output logic                                     res_overflow
);

    localparam int W = bgl_pkg::OPERAND_WIDTH;
    localparam int C = bgl_pkg::CNT_W;

    bgl_pkg::state_t state_reg, state_next;
    logic           cmd_reg,  cmd_next;
    logic [W-1:0]   a_reg,    a_next;
    logic [W-1:0]   b_reg,    b_next;
    logic [W-1:0]   x_reg,    x_next;
    logic [W-1:0]   y_reg,    y_next;
    logic [C-1:0]   twos_reg, twos_next;
    logic [C-1:0]   cnt_reg,  cnt_next;
    logic [W-1:0]   val_reg,  val_next;
    logic           ovf_reg,  ovf_next;

    // shared adder / subtractor
    logic [W:0]     add_a;
    logic [W:0]     add_b;
    logic           add_sub;
    logic [W+1:0]   add_sum;
    logic           borrow;

    always_comb begin
        add_a   = {1'b0, x_reg};
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            bgl_pkg::ST_SUB: begin
                add_a   = {1'b0, y_reg};
                add_b   = {1'b0, x_reg};
                add_sub = 1'b1;
            end
            bgl_pkg::ST_DIV: begin
                add_a   = {x_reg, a_reg[W-1]};
                add_b   = {1'b0, y_reg};
                add_sub = 1'b1;
            end
            bgl_pkg::ST_MUL: begin
                add_a   = {1'b0, x_reg};
                add_b   = a_reg[0] ? {1'b0, b_reg} : '0;
                add_sub = 1'b0;
            end
            default: begin
                add_a   = {1'b0, x_reg};
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + ({1'b0, add_b} ^ {(W+2){add_sub}})
                   + {{(W+1){1'b0}}, add_sub};
    assign borrow  = add_sum[W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bgl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        twos_reg <= twos_next;
        cnt_reg  <= cnt_next;
        val_reg  <= val_next;
        ovf_reg  <= ovf_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        twos_next  = twos_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            bgl_pkg::ST_IDLE: begin
                if (start) begin
                    cmd_next  = cmd;
                    a_next    = op_a;
                    b_next    = op_b;
                    x_next    = op_a;
                    y_next    = op_b;
                    twos_next = '0;
                    ovf_next  = 1'b0;
                    if (op_a == '0 || op_b == '0) begin
                        val_next   = (cmd == bgl_pkg::CMD_GCD) ? (op_a | op_b) : '0;
                        state_next = bgl_pkg::ST_DONE;
                    end else begin
                        state_next = bgl_pkg::ST_STRIP;
                    end
                end
            end
            bgl_pkg::ST_STRIP: begin
                // shared factors of two
                if (!(x_reg[0] | y_reg[0])) begin
                    x_next    = x_reg >> 1;
                    y_next    = y_reg >> 1;
                    twos_next = twos_reg + 1'b1;
                end else begin
                    state_next = bgl_pkg::ST_ODDX;
                end
            end
            bgl_pkg::ST_ODDX: begin
                if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else begin
                    state_next = bgl_pkg::ST_SUB;
                end
            end
            bgl_pkg::ST_SUB: begin
                if (y_reg == '0) begin
                    state_next = bgl_pkg::ST_SCALE;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (borrow) begin
                    x_next = y_reg;
                    y_next = x_reg;
                end else begin
                    // difference of two odd values is even
                    y_next = {1'b0, add_sum[W-1:1]};
                end
            end
            bgl_pkg::ST_SCALE: begin
                if (cmd_reg == bgl_pkg::CMD_GCD) begin
                    val_next   = x_reg << twos_reg;
                    ovf_next   = 1'b0;
                    state_next = bgl_pkg::ST_DONE;
                end else begin
                    y_next     = x_reg << twos_reg;
                    x_next     = '0;
                    cnt_next   = C'(W - 1);
                    state_next = bgl_pkg::ST_DIV;
                end
            end
            bgl_pkg::ST_DIV: begin
                // restoring divide, quotient shifts into a_reg
                a_next = {a_reg[W-2:0], ~borrow};
                x_next = borrow ? {x_reg[W-2:0], a_reg[W-1]} : add_sum[W-1:0];
                if (cnt_reg == '0) begin
                    x_next     = '0;
                    cnt_next   = C'(W - 1);
                    state_next = bgl_pkg::ST_MUL;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            bgl_pkg::ST_MUL: begin
                // shift-add, product high half in x_reg, low half in a_reg
                x_next = add_sum[W:1];
                a_next = {add_sum[0], a_reg[W-1:1]};
                if (cnt_reg == '0) begin
                    val_next   = {add_sum[0], a_reg[W-1:1]};
                    ovf_next   = |add_sum[W:1];
                    state_next = bgl_pkg::ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            bgl_pkg::ST_DONE: begin
                if (ack) begin
                    state_next = bgl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bgl_pkg::ST_IDLE;
            end
        endcase
    end

    assign status.idle  = (state_reg == bgl_pkg::ST_IDLE);
    assign status.done  = (state_reg == bgl_pkg::ST_DONE);
    assign res_value    = val_reg;
    assign res_overflow = ovf_reg;

endmodule

`default_nettype wire

// File: src/binary_gcd_and_lcm_top.sv
// binary_gcd_and_lcm_top: stream wrapper with output register around the gcd / lcm core
// depends on bgl_pkg and bgl_core
`default_nettype none

// One transfer in gives one transfer out. tuser selects gcd (0) or lcm (1); the result
// carries the gcd, or the low bits of the lcm with an overflow flag in tuser. Items are
// worked one at a time on a single shared 66-bit adder/subtractor under a sequencer:
// a gcd runs the shift and subtract loop, and an lcm adds a bit-serial divide and
// multiply after it. A zero operand skips the loop and goes straight to the result.
// The next item is taken as soon as the result has moved into the output register.
module binary_gcd_and_lcm_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [2*bgl_pkg::DATA_W-1:0] s_tdata,  // operand_a, operand_b
    input  wire logic                        s_tuser,  // command
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [bgl_pkg::DATA_W-1:0]   m_tdata,  // value
    output logic                             m_tuser   // overflow
);

    localparam int D = bgl_pkg::DATA_W;
    localparam int W = bgl_pkg::OPERAND_WIDTH;

    bgl_pkg::core_status_t status;
    logic [W-1:0]          res_value;
    logic                  res_overflow;
    logic                  out_free;
    logic                  start;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [D-1:0]          m_tdata_reg,  m_tdata_next;
    logic                  m_tuser_reg,  m_tuser_next;

    assign s_tready = status.idle;
    assign start    = s_tvalid & status.idle;
    assign out_free = !m_tvalid_reg || m_tready;

    bgl_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .cmd          (s_tuser),
        .op_a         (s_tdata[W-1:0]),
        .op_b         (s_tdata[D+W-1:D]),
        .ack          (out_free),
        .status       (status),
        .res_value    (res_value),
        .res_overflow (res_overflow)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_free) begin
            m_tvalid_next = status.done;
            if (status.done) begin
                m_tdata_next = D'(res_value);
                m_tuser_next = res_overflow;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// File: verif/tb_binary_gcd_and_lcm_top.sv
// tb_binary_gcd_and_lcm_top: self-checking testbench for the binary gcd / lcm stream block
// predicts each gcd or lcm result in the testbench and checks it against every output transfer
// depends on bgl_pkg and binary_gcd_and_lcm_top
`timescale 1ns / 100ps

module tb_binary_gcd_and_lcm_top;

    localparam int DATA_W          = bgl_pkg::DATA_W;
    localparam int OPERAND_WIDTH   = bgl_pkg::OPERAND_WIDTH;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 500;
    localparam int HOLD_OFF_CYCLES = 400;

    localparam logic [DATA_W-1:0] WORD_MAX = {DATA_W{1'b1}};

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              overflow;
    } gcd_lcm_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*DATA_W-1:0]   s_tdata  = '0;  // operand_a, operand_b
    logic                  s_tuser  = 1'b0;  // command
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;  // value
    logic                  m_tuser;  // overflow

    gcd_lcm_result_t       expected_results[$];
    gcd_lcm_result_t       oldest_result;
    int unsigned           error_count     = 0;
    int unsigned           stall_cycles    = 0;
    int unsigned           tx_idle_pct     = 22;
    int unsigned           rx_idle_pct     = 22;
    int unsigned           rx_hold_request = 0;
    int unsigned           rx_hold_left    = 0;

    binary_gcd_and_lcm_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [DATA_W-1:0] operand_mask();
        if (OPERAND_WIDTH >= DATA_W)
            return WORD_MAX;
        return (DATA_W'(1) << OPERAND_WIDTH) - 1'b1;
    endfunction

    function automatic logic [DATA_W-1:0] stein_divisor(input logic [DATA_W-1:0] x_in,
                                                        input logic [DATA_W-1:0] y_in);
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] t;
        int unsigned       twos;
        x    = x_in;
        y    = y_in;
        twos = 0;
        if (x == '0)
            return y;
        if (y == '0)
            return x;
        while (!x[0] && !y[0]) begin
            x    = x >> 1;
            y    = y >> 1;
            twos = twos + 1;
        end
        while (!x[0])
            x = x >> 1;
        do begin
            while (!y[0])
                y = y >> 1;
            if (x > y) begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end while (y != '0);
        return x << twos;
    endfunction

    function automatic gcd_lcm_result_t predict_gcd_lcm(input logic              command,
                                                        input logic [DATA_W-1:0] operand_a,
                                                        input logic [DATA_W-1:0] operand_b);
        gcd_lcm_result_t   res;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] quotient;
        mask         = operand_mask();
        a            = operand_a & mask;
        b            = operand_b & mask;
        res.overflow = 1'b0;
        if (command == bgl_pkg::CMD_GCD) begin
            res.value = stein_divisor(a, b);
        end else if (a == '0 || b == '0) begin
            res.value = '0;
        end else begin
            quotient     = a / stein_divisor(a, b);
            res.overflow = (b > mask / quotient);
            res.value    = (quotient * b) & mask;
        end
        res.value = res.value & mask;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] wanted,
                                   input logic [DATA_W-1:0] seen);
        $display("tb: mismatch at %0t: %s, expected 0x%016h, got 0x%016h",
                 $realtime, what, wanted, seen);
        error_count = error_count + 1;
    endtask

    // offers one item, with random idle cycles ahead of it, and waits for its transfer
    task automatic send_operands(input logic command, input logic [DATA_W-1:0] operand_a,
                                 input logic [DATA_W-1:0] operand_b);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= command;
        s_tdata  <= {operand_b, operand_a};
        do
            @(posedge aclk);
        while (!s_tready);
        expected_results.push_back(predict_gcd_lcm(command, operand_a, operand_b));
    endtask

    task automatic draw_operand_pair(output logic [DATA_W-1:0] a, output logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] common;
        case ($urandom_range(0, 7))
            0, 1: begin
                a = random_word();
                b = random_word();
            end
            2: begin
                a = DATA_W'($urandom_range(0, 65535));
                b = DATA_W'($urandom_range(0, 65535));
            end
            3: begin
                common = DATA_W'($urandom_range(1, 1 << 20)) << $urandom_range(0, 20);
                a = common * $urandom_range(1, 1 << 20);
                b = common * $urandom_range(1, 1 << 20);
            end
            4: begin
                a = random_word() << $urandom_range(0, 63);
                b = random_word() >> $urandom_range(0, 63);
            end
            5: begin
                a = random_word() >> $urandom_range(0, 63);
                b = '0;
                if ($urandom_range(0, 1) == 1) begin
                    b = a;
                    a = '0;
                end
            end
            6: begin
                a = random_word() >> $urandom_range(0, 63);
                b = a * $urandom_range(1, 7);
            end
            default: begin
                a = WORD_MAX - $urandom_range(0, 3);
                b = random_word();
            end
        endcase
    endtask

    task automatic send_random_items(input int unsigned count);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        repeat (count) begin
            draw_operand_pair(a, b);
            send_operands($urandom_range(0, 1) ? bgl_pkg::CMD_LCM : bgl_pkg::CMD_GCD, a, b);
        end
    endtask

    task automatic test_directed_cases();
        send_operands(bgl_pkg::CMD_GCD, '0, '0);
        send_operands(bgl_pkg::CMD_GCD, '0, WORD_MAX);
        send_operands(bgl_pkg::CMD_GCD, WORD_MAX, '0);
        send_operands(bgl_pkg::CMD_GCD, WORD_MAX, WORD_MAX);
        send_operands(bgl_pkg::CMD_GCD, 64'd1, WORD_MAX);
        send_operands(bgl_pkg::CMD_GCD, 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_operands(bgl_pkg::CMD_GCD, 64'd12, 64'd18);
        send_operands(bgl_pkg::CMD_GCD, 64'h0000_0003_0000_0000, 64'h0000_0500_0000_0000);
        send_operands(bgl_pkg::CMD_GCD, 64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFB);
        send_operands(bgl_pkg::CMD_GCD, 64'd1, 64'h8000_0000_0000_0000);
        send_operands(bgl_pkg::CMD_LCM, '0, '0);
        send_operands(bgl_pkg::CMD_LCM, '0, 64'd5);
        send_operands(bgl_pkg::CMD_LCM, WORD_MAX, '0);
        send_operands(bgl_pkg::CMD_LCM, WORD_MAX, WORD_MAX);
        send_operands(bgl_pkg::CMD_LCM, WORD_MAX, WORD_MAX - 1'b1);
        send_operands(bgl_pkg::CMD_LCM, 64'd1, WORD_MAX);
        send_operands(bgl_pkg::CMD_LCM, 64'd4, 64'd6);
        send_operands(bgl_pkg::CMD_LCM, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000);
        send_operands(bgl_pkg::CMD_LCM, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_0001);
        send_operands(bgl_pkg::CMD_LCM, 64'h8000_0000_0000_0000, 64'd2);
        send_operands(bgl_pkg::CMD_LCM, 64'h8000_0000_0000_0000, 64'd3);
        send_operands(bgl_pkg::CMD_LCM, 64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0001);
        send_operands(bgl_pkg::CMD_LCM, 64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFB);
    endtask

    task automatic test_random_mix();
        send_random_items(440);
    endtask

    // receiver holds off while items keep coming, so the block fills and stalls its input
    task automatic test_output_backpressure();
        rx_hold_request = HOLD_OFF_CYCLES;
        send_random_items(30);
    endtask

    task automatic test_full_rate();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_items(100);
        tx_idle_pct = 22;
        rx_idle_pct = 22;
    endtask

    // sender pauses until every result has come before each burst
    task automatic test_drain_between_bursts();
        repeat (3) begin
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while (expected_results.size() != 0);
            send_random_items(20);
        end
    endtask

    always @(posedge aclk) begin
        if (rx_hold_request != 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid === 1'b1 && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected", '0, m_tdata);
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_tdata !== oldest_result.value)
                    report_mismatch("value", oldest_result.value, m_tdata);
                if (m_tuser !== oldest_result.overflow)
                    report_mismatch("overflow", DATA_W'(oldest_result.overflow),
                                    DATA_W'(m_tuser));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired at %0t", $realtime);
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_mix();
        test_output_backpressure();
        test_full_rate();
        test_drain_between_bursts();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("results never arrived", '0, DATA_W'(expected_results.size()));
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
